FILE: hdl/assert_macros.svh
// Assertion macros shared by the guard RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SDG_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled in reset
`define SDG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hdl/sdg_pkg.sv
// Types and constants of the solver divergence guard.
package sdg_pkg;

    localparam int FLIP_BITS = 8;
    localparam logic [FLIP_BITS-1:0] FLIP_MAX = 8'd255;
    localparam logic [FLIP_BITS-1:0] PERSIST_FLIPS = 8'd5;

    localparam int OSC_FACTOR = 10;
    localparam int PERSIST_FACTOR = 50;

    localparam logic [15:0] GROWTH_RESET = 16'd512;
    localparam logic [15:0] SETTLE_RESET = 16'd655;

    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_NONFINITE = 3'd1;
    localparam logic [2:0] ST_GROWTH = 3'd2;
    localparam logic [2:0] ST_OSC = 3'd3;
    localparam logic [2:0] ST_PERSIST = 3'd4;
    localparam logic [2:0] ST_REGION = 3'd5;

    localparam logic REG_GROWTH = 1'b0;
    localparam logic REG_SETTLE = 1'b1;

    localparam logic KIND_RESIDUAL = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic                 history_invalid;
        logic                 damping;
        logic [FLIP_BITS-1:0] flip_count;
        logic                 region_seen;
    } sdg_flags_t;

endpackage

FILE: hdl/sdg_eval.sv
// Next-state and status evaluation for one word of the guard.
module sdg_eval
    import sdg_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  kind,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  not_finite,
    input  logic [15:0]           growth_ratio,
    input  logic [15:0]           settle_threshold,
    input  sdg_flags_t            flags,
    input  logic [VALUE_BITS-1:0] last_peak,
    input  logic [VALUE_BITS-1:0] older_peak,
    input  logic [VALUE_BITS-1:0] last_region_max,
    input  logic [VALUE_BITS-1:0] running_region_max,
    output sdg_flags_t            flags_next,
    output logic [VALUE_BITS-1:0] last_peak_next,
    output logic [VALUE_BITS-1:0] older_peak_next,
    output logic [VALUE_BITS-1:0] last_region_max_next,
    output logic [VALUE_BITS-1:0] running_region_max_next,
    output logic [2:0]            status
);

    localparam int VB = VALUE_BITS;

    logic [VB-1:0]    diff;
    logic [VB+15:0]   grow_lhs;
    logic [VB+15:0]   grow_rhs;
    logic [VB+15:0]   settle_lhs;
    logic [VB+15:0]   settle_rhs;
    logic [VB+3:0]    osc_lhs;
    logic [VB+5:0]    persist_lhs;
    logic             flip;
    logic             hist_ok;
    logic [FLIP_BITS-1:0] flip_inc;

    assign diff = (value > last_peak) ? value - last_peak : last_peak - value;
    assign grow_lhs = {8'd0, value, 8'd0};
    assign grow_rhs = {16'd0, last_peak} * {{VB{1'b0}}, growth_ratio};
    assign settle_lhs = {diff, 16'd0};
    assign settle_rhs = {16'd0, last_peak} * {{VB{1'b0}}, settle_threshold};
    assign osc_lhs = {4'd0, diff} * (VB+4)'(OSC_FACTOR);
    assign persist_lhs = {6'd0, diff} * (VB+6)'(PERSIST_FACTOR);
    assign flip = (last_peak > older_peak) != (value > last_peak);
    assign hist_ok = (older_peak != '0) && (last_peak != '0) && (value != '0);
    assign flip_inc = (flags.flip_count == FLIP_MAX) ? FLIP_MAX :
                      flags.flip_count + FLIP_BITS'(1);

    always_comb begin
        flags_next = flags;
        last_peak_next = last_peak;
        older_peak_next = older_peak;
        last_region_max_next = last_region_max;
        running_region_max_next = running_region_max;
        status = ST_NONE;
        if (kind == KIND_RESIDUAL) begin
            if (!not_finite) begin
                if (value > running_region_max) begin
                    running_region_max_next = value;
                end
                flags_next.region_seen = 1'b1;
            end
        end else begin
            running_region_max_next = '0;
            flags_next.region_seen = 1'b0;
            if (not_finite) begin
                flags_next.damping = 1'b1;
                older_peak_next = last_peak;
                last_peak_next = '0;
                flags_next.history_invalid = 1'b1;
                status = ST_NONFINITE;
            end else if (flags.history_invalid) begin
                older_peak_next = '0;
                last_peak_next = value;
                flags_next.history_invalid = 1'b0;
            end else begin
                older_peak_next = last_peak;
                last_peak_next = value;
                if ((last_peak != '0) && (grow_lhs > grow_rhs)) begin
                    status = ST_GROWTH;
                end else begin
                    if (hist_ok) begin
                        flags_next.flip_count = flip ? flip_inc : '0;
                        if (flip && (osc_lhs > {4'd0, last_peak})) begin
                            flags_next.damping = 1'b1;
                            status = ST_OSC;
                        end else if ((flags_next.flip_count >= PERSIST_FLIPS) &&
                                     (persist_lhs > {6'd0, last_peak})) begin
                            flags_next.damping = 1'b1;
                            flags_next.flip_count = '0;
                            status = ST_PERSIST;
                        end
                    end
                    if ((status == ST_NONE) && flags.region_seen) begin
                        if ((last_region_max != '0) &&
                            ({1'b0, running_region_max} > {last_region_max, 1'b0})) begin
                            status = ST_REGION;
                        end
                        last_region_max_next = running_region_max;
                    end
                    if ((status == ST_NONE) && flags_next.damping && (last_peak != '0) &&
                        (settle_lhs < settle_rhs)) begin
                        flags_next.damping = 1'b0;
                    end
                end
            end
        end
    end

endmodule

FILE: hdl/solver_divergence_guard.sv
// Top level of the solver divergence guard: ports, registers and config.
//
//  channel   dir   handshake         payload
//  s_        in    s_tvalid/tready   tdata: value; tuser: kind, not_finite
//  m_        out   m_tvalid/tready   tdata: status, restart_iteration, damping_on
//  apb       in    psel/penable      growth_ratio @0x0, settle_threshold @0x4
//
//  One word per cycle unless a tick word waits: a word is held in the input
//  register, then the evaluation logic updates the guard state and tick results.
//  Residual words produce no result and never wait on the output side.
//  A tick word waits only while the result register is full and not taken.
//  Reset (aresetn low, synchronous) clears state and restores register defaults.
`include "assert_macros.svh"

module solver_divergence_guard
    import sdg_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // value
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // [0] kind, [1] not_finite
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [2:0] status, [3] restart_iteration, [4] damping_on, [7:5] zero
    output logic [7:0]                            m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [15:0]           growth_reg;
    logic [15:0]           settle_reg;
    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic                  in_nf_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    sdg_flags_t            flags_reg;
    sdg_flags_t            flags_next;
    logic [VALUE_BITS-1:0] last_peak_reg;
    logic [VALUE_BITS-1:0] last_peak_next;
    logic [VALUE_BITS-1:0] older_peak_reg;
    logic [VALUE_BITS-1:0] older_peak_next;
    logic [VALUE_BITS-1:0] last_region_reg;
    logic [VALUE_BITS-1:0] last_region_next;
    logic [VALUE_BITS-1:0] run_region_reg;
    logic [VALUE_BITS-1:0] run_region_next;
    logic [2:0]            status_next;
    logic                  out_valid_reg;
    logic [2:0]            out_status_reg;
    logic                  out_damp_reg;
    logic                  advance;
    logic                  cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_GROWTH) ? {16'd0, growth_reg} : {16'd0, settle_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            growth_reg <= GROWTH_RESET;
            settle_reg <= SETTLE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_GROWTH) begin
                growth_reg <= pwdata[15:0];
            end else begin
                settle_reg <= pwdata[15:0];
            end
        end
    end

    assign advance = in_valid_reg &&
                     ((in_kind_reg == KIND_RESIDUAL) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser[0];
            in_nf_reg <= s_tuser[1];
            in_value_reg <= s_tdata[VALUE_BITS-1:0];
        end
    end

    sdg_eval #(
        .VALUE_BITS(VALUE_BITS)
    ) u_eval (
        .kind                    (in_kind_reg),
        .value                   (in_value_reg),
        .not_finite              (in_nf_reg),
        .growth_ratio            (growth_reg),
        .settle_threshold        (settle_reg),
        .flags                   (flags_reg),
        .last_peak               (last_peak_reg),
        .older_peak              (older_peak_reg),
        .last_region_max         (last_region_reg),
        .running_region_max      (run_region_reg),
        .flags_next              (flags_next),
        .last_peak_next          (last_peak_next),
        .older_peak_next         (older_peak_next),
        .last_region_max_next    (last_region_next),
        .running_region_max_next (run_region_next),
        .status                  (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            last_peak_reg <= '0;
            older_peak_reg <= '0;
            last_region_reg <= '0;
            run_region_reg <= '0;
        end else if (advance) begin
            flags_reg <= flags_next;
            last_peak_reg <= last_peak_next;
            older_peak_reg <= older_peak_next;
            last_region_reg <= last_region_next;
            run_region_reg <= run_region_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && (in_kind_reg == KIND_TICK)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (in_kind_reg == KIND_TICK)) begin
            out_status_reg <= status_next;
            out_damp_reg <= flags_next.damping;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'd0, out_damp_reg, out_status_reg != ST_NONE, out_status_reg};

    `SDG_ASSERT_IMPLY(a_nonfinite_damps, aclk, aresetn,
        out_valid_reg && (out_status_reg == ST_NONFINITE), out_damp_reg)
    `SDG_ASSERT_IMPLY(a_osc_damps, aclk, aresetn,
        out_valid_reg && ((out_status_reg == ST_OSC) || (out_status_reg == ST_PERSIST)),
        out_damp_reg)
    `SDG_ASSERT_IMPLY(a_invalid_clears_peak, aclk, aresetn,
        flags_reg.history_invalid, last_peak_reg == '0)
    `SDG_ASSERT_NEXT(a_residual_no_result, aclk, aresetn,
        advance && (in_kind_reg == KIND_RESIDUAL) && !out_valid_reg, !out_valid_reg)

endmodule

FILE: tb/solver_divergence_guard_test.sv
// Testbench for the solver divergence guard: directed words, register sweeps, random words.
module solver_divergence_guard_test;
    import sdg_pkg::*;

    localparam int IDLE_CYCLES = 8;

    typedef struct packed {
        logic [2:0] status;
        logic       restart;
        logic       damping;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [15:0] cfg_growth = GROWTH_RESET;
    logic [15:0] cfg_settle = SETTLE_RESET;
    logic [31:0] pk_last = '0;
    logic [31:0] pk_older = '0;
    logic        hist_bad = 1'b0;
    logic        damp = 1'b0;
    logic [7:0]  flips = '0;
    logic [31:0] region_last = '0;
    logic [31:0] region_run = '0;
    logic        region_seen = 1'b0;

    verdict_t    verdicts_due[$];
    verdict_t    want;
    int          mismatches = 0;
    int          stall_left = 0;
    logic        calm_in = 1'b0;
    logic        calm_out = 1'b0;
    logic [31:0] walk = 32'h0064_0000;
    logic        rising = 1'b1;
    logic [31:0] region_level = 32'h0001_0000;

    solver_divergence_guard dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic guard_predict(input logic kind, input logic [31:0] val, input logic nf);
        logic [31:0] prev, older, cur_max, d;
        logic        had_region, shift, osc;
        logic [2:0]  st;
        verdict_t    v;
        prev = pk_last;
        older = pk_older;
        had_region = region_seen;
        cur_max = region_run;
        d = (val > prev) ? val - prev : prev - val;
        st = ST_NONE;
        shift = 1'b1;
        if (kind == KIND_RESIDUAL) begin
            if (!nf) begin
                if (val > region_run) region_run = val;
                region_seen = 1'b1;
            end
            return;
        end
        region_run = '0;
        region_seen = 1'b0;
        if (nf) begin
            damp = 1'b1;
            pk_older = prev;
            pk_last = '0;
            hist_bad = 1'b1;
            st = ST_NONFINITE;
            shift = 1'b0;
        end else if (hist_bad) begin
            pk_older = '0;
            pk_last = val;
            hist_bad = 1'b0;
            shift = 1'b0;
        end else if (prev != 0 && 64'(val) * 256 > 64'(prev) * cfg_growth) begin
            st = ST_GROWTH;
        end else begin
            if (older != 0 && prev != 0 && val != 0) begin
                osc = (prev > older) != (val > prev);
                if (osc) begin
                    if (flips != FLIP_MAX) flips = flips + 8'd1;
                end else begin
                    flips = '0;
                end
                if (osc && 64'(d) * OSC_FACTOR > 64'(prev)) begin
                    damp = 1'b1;
                    st = ST_OSC;
                end else if (flips >= PERSIST_FLIPS && 64'(d) * PERSIST_FACTOR > 64'(prev)) begin
                    damp = 1'b1;
                    flips = '0;
                    st = ST_PERSIST;
                end
            end
            if (st == ST_NONE && had_region) begin
                if (region_last != 0 && 64'(cur_max) > 64'(region_last) * 2) st = ST_REGION;
                region_last = cur_max;
            end
            if (st == ST_NONE && damp && prev != 0 &&
                64'(d) * 65536 < 64'(prev) * cfg_settle)
                damp = 1'b0;
        end
        if (shift) begin
            pk_older = prev;
            pk_last = val;
        end
        v.status = st;
        v.restart = (st != ST_NONE);
        v.damping = damp;
        verdicts_due.push_back(v);
    endtask

    task automatic send_word(input logic kind, input logic [31:0] val, input logic nf);
        int gap;
        gap = calm_in ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= val;
        s_tuser <= {nf, kind};
        do @(posedge aclk); while (!s_tready);
        guard_predict(kind, val, nf);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(input logic idx, input logic [15:0] val);
        logic [31:0] back;
        apb_read({idx, 2'b00}, back);
        if (back !== {16'h0, val}) begin
            $error("register %0d: expected %0d, actual %0d", idx, val, back);
            mismatches++;
        end
    endtask

    task automatic set_register(input logic idx, input logic [15:0] val);
        apb_write({idx, 2'b00}, {16'($urandom), val});
        if (idx == REG_GROWTH) cfg_growth = val;
        else cfg_settle = val;
        check_register(idx, val);
    endtask

    // wait until the guard is idle: no result pending, no residual word in flight
    task automatic settle_down();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic drive_ticks(input int ticks);
        int          r, res_n;
        logic [31:0] step;
        for (int t = 0; t < ticks; t++) begin
            if (t % 25 == 0) begin
                calm_in = ($urandom_range(0, 3) == 0);
                calm_out = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0)
                send_word(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
            r = $urandom_range(0, 99);
            if (r < 10) region_level = region_level * 3;
            else if (r < 20) region_level = region_level >> 1;
            if (region_level < 16 || region_level > 32'h4000_0000)
                region_level = $urandom_range(32'h100, 32'h0100_0000);
            res_n = $urandom_range(0, 3);
            for (int k = 0; k < res_n; k++)
                send_word(KIND_RESIDUAL, region_level >> $urandom_range(0, 2),
                          $urandom_range(0, 19) == 0);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_word(KIND_TICK, $urandom, 1'b1);
            end else if (r < 6) begin
                send_word(KIND_TICK, $urandom, 1'b0);
            end else if (r < 9) begin
                send_word(KIND_TICK, '0, 1'b0);
            end else begin
                if (r < 14) begin
                    walk = walk * 3;
                end else begin
                    step = walk >> $urandom_range(1, 8);
                    if ($urandom_range(0, 3) != 0) rising = !rising;
                    walk = rising ? walk + step : walk - step;
                end
                send_word(KIND_TICK, walk, 1'b0);
                if (walk < 256 || walk > 32'hA000_0000)
                    walk = $urandom_range(32'h1_0000, 32'h1000_0000);
            end
        end
    endtask

    task automatic test_register_defaults();
        check_register(REG_GROWTH, GROWTH_RESET);
        check_register(REG_SETTLE, SETTLE_RESET);
    endtask

    task automatic test_directed();
        localparam logic [31:0] U = 32'h0001_0000;
        send_word(KIND_TICK, 100 * U, 1'b0);
        send_word(KIND_RESIDUAL, 10 * U, 1'b0);
        send_word(KIND_RESIDUAL, 999 * U, 1'b1);
        send_word(KIND_TICK, 105 * U, 1'b0);
        send_word(KIND_RESIDUAL, 25 * U, 1'b0);
        send_word(KIND_TICK, 95 * U, 1'b0);
        send_word(KIND_TICK, 200 * U, 1'b0);
        send_word(KIND_TICK, 150 * U, 1'b0);
        send_word(KIND_TICK, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_RESIDUAL, 32'hFFFF_FFFF, 1'b0);
        send_word(KIND_TICK, '0, 1'b0);
        send_word(KIND_TICK, 32'hFFFF_FFFF, 1'b0);
        send_word(KIND_TICK, 32'hFFFF_0000, 1'b0);
        // alternating 5% swings build up a persistent oscillation
        send_word(KIND_TICK, 1000 * U, 1'b0);
        send_word(KIND_TICK, 1050 * U, 1'b0);
        send_word(KIND_TICK, 1000 * U, 1'b0);
        send_word(KIND_TICK, 1050 * U, 1'b0);
        send_word(KIND_TICK, 1000 * U, 1'b0);
        send_word(KIND_TICK, 1050 * U, 1'b0);
        send_word(KIND_TICK, 1051 * U, 1'b0);
        send_word(KIND_TICK, '0, 1'b0);
        send_word(KIND_TICK, 1051 * U, 1'b0);
        settle_down();
    endtask

    task automatic test_register_sweep();
        logic [15:0] growth_set[5] = '{16'd0, 16'hFFFF, 16'd256, 16'($urandom), GROWTH_RESET};
        logic [15:0] settle_set[5] = '{16'd0, 16'hFFFF, 16'($urandom), 16'($urandom),
                                       SETTLE_RESET};
        for (int p = 0; p < 5; p++) begin
            set_register(REG_GROWTH, growth_set[p]);
            set_register(REG_SETTLE, settle_set[p]);
            drive_ticks(40);
            settle_down();
        end
    endtask

    task automatic test_random_traffic();
        drive_ticks(200);
        settle_down();
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left <= calm_out ? 0 : pick_gap();
            m_tready <= (stall_left == 0) && (calm_out || $urandom_range(0, 1) == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[3] !== want.restart) begin
                    $error("restart_iteration: expected %0d, actual %0d", want.restart,
                           m_tdata[3]);
                    mismatches++;
                end
                if (m_tdata[4] !== want.damping) begin
                    $error("damping_on: expected %0d, actual %0d", want.damping, m_tdata[4]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_defaults();
        test_directed();
        test_register_sweep();
        test_random_traffic();
        repeat (IDLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
